// File: rtl/cbor_pkg.sv
// Shared types and constants for the CAN bus-off recovery supervisor.
// Used by every module of the block; depends on nothing.

package cbor_pkg;

    // Supervisor / controller state codes
    localparam logic [1:0] MODE_STOPPED    = 2'd0;
    localparam logic [1:0] MODE_RUNNING    = 2'd1;
    localparam logic [1:0] MODE_BUS_OFF    = 2'd2;
    localparam logic [1:0] MODE_RECOVERING = 2'd3;

    // Item operations
    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_INTERVAL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_THRESH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_WINDOW      = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RETRY_INTERVAL_RST   = 16'd1000;
    localparam logic [15:0] BACKOFF_INTERVAL_RST = 16'd10000;
    localparam logic [7:0]  BACKOFF_THRESH_RST   = 8'd5;
    localparam logic [15:0] RATE_WINDOW_RST      = 16'd1000;

    // Saturation limit of the failed restart count
    localparam logic [7:0] FAILED_MAX = 8'd255;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic        status_valid;
        logic [1:0]  bus_state;
        logic [7:0]  tx_error_count;
        logic [7:0]  rx_error_count;
        logic [31:0] rx_overrun_total;
        logic [31:0] rx_frames_total;
        logic        recovery_accepted;
        logic        start_accepted;
    } item_t;

    typedef struct packed {
        logic [1:0]  drive_state;
        logic        recovery_requested;
        logic        restart_requested;
        logic [31:0] frames_per_window;
        logic [7:0]  tx_errors_seen;
        logic [7:0]  rx_errors_seen;
        logic [31:0] overruns_seen;
        logic [31:0] bus_off_events;
        logic [31:0] recoveries_done;
        logic [7:0]  failed_restarts;
    } result_t;

    // Post-update view from the recovery state machine
    typedef struct packed {
        logic [1:0]  drive_state;
        logic        recovery_requested;
        logic        restart_requested;
        logic [31:0] bus_off_events;
        logic [31:0] recoveries_done;
        logic [7:0]  failed_restarts;
    } ctrl_view_t;

    // Post-update view from the statistics unit
    typedef struct packed {
        logic [31:0] frames_per_window;
        logic [7:0]  tx_errors_seen;
        logic [7:0]  rx_errors_seen;
        logic [31:0] overruns_seen;
    } stats_view_t;

endpackage

// File: rtl/can_bus_off_recovery_supervisor.sv
// CAN bus-off recovery supervisor, top level. An item passes the input register,
// then the result register; the state is updated in one step as it advances.
// Throughput: one item per cycle while result_stall is low.
// Reset (rst_n low, asynchronous): supervisor stopped, counters and rate window
// cleared, configuration at 1000 / 10000 / 5 / 1000. No clearing pass.
// Depends on cbor_pkg, cbor_ctrl and cbor_stats.

module can_bus_off_recovery_supervisor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  cbor_pkg::item_t                      item_data,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output cbor_pkg::result_t                    result_data,
    input  logic                                 cfg_we,
    input  logic [cbor_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cbor_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import cbor_pkg::*;

    logic [15:0] retry_iv_reg;
    logic [15:0] backoff_iv_reg;
    logic [7:0]  backoff_th_reg;
    logic [15:0] rate_win_reg;

    logic        in_full_reg;
    item_t       in_item_reg;
    logic        res_valid_reg;
    result_t     res_reg;
    logic        advance;
    ctrl_view_t  ctrl_view;
    stats_view_t stats_view;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_iv_reg   <= RETRY_INTERVAL_RST;
            backoff_iv_reg <= BACKOFF_INTERVAL_RST;
            backoff_th_reg <= BACKOFF_THRESH_RST;
            rate_win_reg   <= RATE_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RETRY_INTERVAL:   retry_iv_reg   <= cfg_data;
                CFG_BACKOFF_INTERVAL: backoff_iv_reg <= cfg_data;
                CFG_BACKOFF_THRESH:   backoff_th_reg <= cfg_data[7:0];
                CFG_RATE_WINDOW:      rate_win_reg   <= cfg_data;
            endcase
        end
    end

    // Held item moves on when the result register is free or being drained
    assign advance    = in_full_reg && (!res_valid_reg || !result_stall);
    assign item_stall = in_full_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (item_valid && !item_stall)
            in_full_reg <= 1'b1;
        else if (advance)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_item_reg <= item_data;
    end

    cbor_ctrl u_ctrl (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (advance),
        .item                (in_item_reg),
        .retry_interval_ms   (retry_iv_reg),
        .backoff_interval_ms (backoff_iv_reg),
        .backoff_threshold   (backoff_th_reg),
        .view                (ctrl_view)
    );

    cbor_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .item           (in_item_reg),
        .rate_window_ms (rate_win_reg),
        .view           (stats_view)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.drive_state        <= ctrl_view.drive_state;
            res_reg.recovery_requested <= ctrl_view.recovery_requested;
            res_reg.restart_requested  <= ctrl_view.restart_requested;
            res_reg.frames_per_window  <= stats_view.frames_per_window;
            res_reg.tx_errors_seen     <= stats_view.tx_errors_seen;
            res_reg.rx_errors_seen     <= stats_view.rx_errors_seen;
            res_reg.overruns_seen      <= stats_view.overruns_seen;
            res_reg.bus_off_events     <= ctrl_view.bus_off_events;
            res_reg.recoveries_done    <= ctrl_view.recoveries_done;
            res_reg.failed_restarts    <= ctrl_view.failed_restarts;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

endmodule

// File: rtl/cbor_stats.sv
// Statistics unit: held error counters, overrun count and frame rate window.
// Depends on cbor_pkg.

module cbor_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cbor_pkg::item_t     item,
    input  logic [15:0]         rate_window_ms,
    output cbor_pkg::stats_view_t view
);
    import cbor_pkg::*;

    logic        window_open_reg, window_open_next;
    logic [31:0] win_time_reg, win_time_next;
    logic [31:0] win_frames_reg, win_frames_next;
    logic [31:0] frame_rate_reg, frame_rate_next;
    logic [7:0]  tx_hold_reg, tx_hold_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic [31:0] ovr_hold_reg, ovr_hold_next;
    logic [31:0] elapsed;
    logic        poll;
    logic        close_window;

    assign poll         = step && (item.operation == OP_POLL);
    assign elapsed      = item.now_ms - win_time_reg;
    assign close_window = !window_open_reg || (elapsed >= {16'd0, rate_window_ms});

    // Next values of the held status and the rate window
    always_comb
    begin
        window_open_next = window_open_reg;
        win_time_next    = win_time_reg;
        win_frames_next  = win_frames_reg;
        frame_rate_next  = frame_rate_reg;
        tx_hold_next     = tx_hold_reg;
        rx_hold_next     = rx_hold_reg;
        ovr_hold_next    = ovr_hold_reg;
        if (poll)
        begin
            if (item.status_valid)
            begin
                tx_hold_next  = item.tx_error_count;
                rx_hold_next  = item.rx_error_count;
                ovr_hold_next = item.rx_overrun_total;
            end
            if (close_window)
            begin
                frame_rate_next  = item.rx_frames_total - win_frames_reg;
                win_frames_next  = item.rx_frames_total;
                win_time_next    = item.now_ms;
                window_open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_open_reg <= 1'b0;
            win_time_reg    <= '0;
            win_frames_reg  <= '0;
            frame_rate_reg  <= '0;
            tx_hold_reg     <= '0;
            rx_hold_reg     <= '0;
            ovr_hold_reg    <= '0;
        end
        else
        begin
            window_open_reg <= window_open_next;
            win_time_reg    <= win_time_next;
            win_frames_reg  <= win_frames_next;
            frame_rate_reg  <= frame_rate_next;
            tx_hold_reg     <= tx_hold_next;
            rx_hold_reg     <= rx_hold_next;
            ovr_hold_reg    <= ovr_hold_next;
        end
    end

    assign view.frames_per_window = frame_rate_next;
    assign view.tx_errors_seen    = tx_hold_next;
    assign view.rx_errors_seen    = rx_hold_next;
    assign view.overruns_seen     = ovr_hold_next;

endmodule

// File: rtl/cbor_ctrl.sv
// Recovery FSM: stopped, running, bus off, recovering, with retry/backoff timing.
// Depends on cbor_pkg.

module cbor_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  cbor_pkg::item_t      item,
    input  logic [15:0]          retry_interval_ms,
    input  logic [15:0]          backoff_interval_ms,
    input  logic [7:0]           backoff_threshold,
    output cbor_pkg::ctrl_view_t view
);
    import cbor_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [31:0] retry_time_reg, retry_time_next;
    logic [7:0]  failed_reg, failed_next;
    logic [31:0] bus_off_cnt_reg, bus_off_cnt_next;
    logic [31:0] recov_cnt_reg, recov_cnt_next;
    logic        rec_req;
    logic        rst_req;
    logic [1:0]  bus_eff;
    logic [31:0] since_due;
    logic [7:0]  failed_inc;
    logic [15:0] wait_ms;

    // An unreadable status counts as a stopped controller
    assign bus_eff    = item.status_valid ? item.bus_state : MODE_STOPPED;
    assign since_due  = item.now_ms - retry_time_reg;
    assign failed_inc = (failed_reg < FAILED_MAX) ? failed_reg + 8'd1 : failed_reg;
    assign wait_ms    = (failed_inc >= backoff_threshold) ? backoff_interval_ms
                                                           : retry_interval_ms;

    // Mode transitions and counters
    always_comb
    begin
        mode_next        = mode_reg;
        retry_time_next  = retry_time_reg;
        failed_next      = failed_reg;
        bus_off_cnt_next = bus_off_cnt_reg;
        recov_cnt_next   = recov_cnt_reg;
        rec_req          = 1'b0;
        rst_req          = 1'b0;
        if (step)
        begin
            if (item.operation == OP_START)
            begin
                mode_next = MODE_RUNNING;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_STOPPED:
                    begin
                        // statistics only
                    end
                    MODE_RUNNING:
                    begin
                        if (bus_eff == MODE_BUS_OFF)
                        begin
                            bus_off_cnt_next = bus_off_cnt_reg + 32'd1;
                            mode_next        = MODE_BUS_OFF;
                            retry_time_next  = item.now_ms;
                        end
                    end
                    MODE_BUS_OFF:
                    begin
                        // wrap-aware: due when the difference is not negative
                        if (!since_due[31])
                        begin
                            rec_req = 1'b1;
                            if (item.recovery_accepted)
                                mode_next = MODE_RECOVERING;
                            else
                                retry_time_next = item.now_ms + {16'd0, retry_interval_ms};
                        end
                    end
                    MODE_RECOVERING:
                    begin
                        if (bus_eff == MODE_STOPPED)
                        begin
                            rst_req = 1'b1;
                            if (item.start_accepted)
                            begin
                                recov_cnt_next = recov_cnt_reg + 32'd1;
                                failed_next    = '0;
                                mode_next      = MODE_RUNNING;
                            end
                            else
                            begin
                                failed_next     = failed_inc;
                                mode_next       = MODE_BUS_OFF;
                                retry_time_next = item.now_ms + {16'd0, wait_ms};
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_STOPPED;
            retry_time_reg  <= '0;
            failed_reg      <= '0;
            bus_off_cnt_reg <= '0;
            recov_cnt_reg   <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            retry_time_reg  <= retry_time_next;
            failed_reg      <= failed_next;
            bus_off_cnt_reg <= bus_off_cnt_next;
            recov_cnt_reg   <= recov_cnt_next;
        end
    end

    assign view.drive_state        = mode_next;
    assign view.recovery_requested = rec_req;
    assign view.restart_requested  = rst_req;
    assign view.bus_off_events     = bus_off_cnt_next;
    assign view.recoveries_done    = recov_cnt_next;
    assign view.failed_restarts    = failed_next;

endmodule
